### src/flb_pkg.sv
package flb_pkg;

   localparam int MAX_ORBITALS_DEF = 64;
   localparam int EXP_TABLE_DEPTH_DEF = 256;
   localparam int SUM_TOL = 655;
   localparam int WIDTH_TOL = 33;
   localparam int T_MAX = 1048576;

   typedef enum logic [1:0] {
      CSR_ELECTRON_COUNT = 2'd0,
      CSR_ORBITAL_COUNT  = 2'd1,
      CSR_INV_TEMP       = 2'd2,
      CSR_ITER_LIMIT     = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_SOLVE = 1'b1
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RANK_RD,
      ST_RANK_LATCH,
      ST_RANK_SWEEP,
      ST_SUM,
      ST_EVAL,
      ST_OUT_ISSUE,
      ST_OUT_WAIT,
      ST_OUT_PUSH
   } state_type;

   typedef struct packed {
      logic        action;
      logic [5:0]  orbital_index;
      logic [31:0] energy;
   } req_type;

   typedef struct packed {
      logic [5:0]  result_index;
      logic [16:0] occupation;
      logic [31:0] fermi_level;
      logic        converged;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  electron_count;
      logic [6:0]  orbital_count;
      logic [31:0] inverse_temperature;
      logic [8:0]  iteration_limit;
   } cfg_type;

   localparam logic [63:0] NEG_EXP_Q30 [17] = '{
      64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458458, 64'd19666268,
      64'd7234816, 64'd2661539, 64'd979126, 64'd360200, 64'd132510, 64'd48748,
      64'd17933, 64'd6597, 64'd2427, 64'd893, 64'd328, 64'd121
   };

   // Restoring division, only ever evaluated while the table constants are built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
      logic [63:0] q;
      logic [64:0] rem;
      q = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, dvs}) begin
            rem = rem - {1'b0, dvs};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [16:0] half_occ_at(input logic [63:0] t);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] term;
      logic signed [63:0] acc;
      logic [63:0] e;
      logic [63:0] den;
      n = t >> 16;
      r = t & 64'hFFFF;
      term = 64'd1 << 32;
      acc = $signed(term);
      if (n > 64'd16) n = 64'd16;
      for (int k = 1; k <= 12; k++) begin
         term = udiv64(term * r, 64'd65536 * 64'(k));
         if (k[0]) acc = acc - $signed(term);
         else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      e = (64'(acc) * NEG_EXP_Q30[n[4:0]]) >> 30;
      den = (64'd1 << 32) + e;
      return 17'(udiv64((e << 16) + (den >> 1), den));
   endfunction

   function automatic logic [31:0] midpoint(input logic [31:0] lo, input logic [31:0] hi);
      logic [32:0] w;
      w = {hi[31], hi} - {lo[31], lo};
      return lo + w[32:1];
   endfunction

endpackage

### src/flb_fifo.sv
module flb_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] data_in,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] data_out
);
   logic [WIDTH-1:0] slot_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign data_out = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      count_in = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= data_in;
   end
endmodule

### src/flb_occ.sv
module flb_occ #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] energy,
   input  logic [31:0] probe,
   input  logic [31:0] beta,
   output logic        out_valid,
   output logic [16:0] occupation
);
   import flb_pkg::*;

   localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int DW = $clog2(EXP_TABLE_DEPTH) + 1;

   logic [16:0] tbl [EXP_TABLE_DEPTH + 1];

   for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : gen_tbl
      localparam logic [63:0] T_POINT = (64'(g) << 20) / 64'(EXP_TABLE_DEPTH);
      localparam logic [16:0] ENTRY = half_occ_at(T_POINT);
      assign tbl[g] = ENTRY;
   end

   logic [32:0] d;
   logic [31:0] mag;
   logic [63:0] prod;
   logic [20:0] t_in;
   logic [20:0] t_ff;
   logic neg1_ff, neg2_ff, v1_ff, v2_ff, v3_ff;

   logic [20+DW:0] p;
   logic [20+DW-20:0] idx;
   logic [16:0] a_in, b_in, a_ff, b_ff;
   logic [19:0] fr_ff;
   logic [16:0] hi_v, lo_v;
   logic [36:0] scaled;
   logic [16:0] g;
   logic [16:0] occ_ff;

   always_comb begin
      d = {energy[31], energy} - {probe[31], probe};
      mag = d[32] ? 32'(-d) : d[31:0];
      prod = 64'(mag) * 64'(beta);
      if ((prod >> 24) > 64'(T_MAX)) t_in = 21'(T_MAX);
      else t_in = prod[44:24];
   end

   always_comb begin
      p = (21 + DW)'(t_ff) * (21 + DW)'(EXP_TABLE_DEPTH);
      idx = p[20+DW:20];
      if (idx >= (DW + 1)'(EXP_TABLE_DEPTH)) begin
         a_in = tbl[EXP_TABLE_DEPTH];
         b_in = tbl[EXP_TABLE_DEPTH];
      end else begin
         a_in = tbl[idx[TW-1:0]];
         b_in = tbl[idx[TW-1:0] + TW'(1)];
      end
   end

   always_comb begin
      if (a_ff >= b_ff) begin
         hi_v = a_ff - b_ff;
      end else begin
         hi_v = b_ff - a_ff;
      end
      scaled = 37'(hi_v) * 37'(fr_ff);
      lo_v = scaled[36:20];
      g = (a_ff >= b_ff) ? a_ff - lo_v : a_ff + lo_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      neg1_ff <= d[32];
      a_ff <= a_in;
      b_ff <= b_in;
      fr_ff <= (idx >= (DW + 1)'(EXP_TABLE_DEPTH)) ? 20'd0 : p[19:0];
      neg2_ff <= neg1_ff;
      occ_ff <= neg2_ff ? 17'd65536 - g : g;
   end

   assign out_valid = v3_ff;
   assign occupation = occ_ff;
endmodule

### src/flb_back.sv
module flb_back #(
   parameter int MAX_ORBITALS = 64,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  flb_pkg::cfg_type cfg,
   input  logic             in_empty,
   input  flb_pkg::req_type in_data,
   output logic             in_pop,
   input  logic             out_full,
   output logic             out_push,
   output flb_pkg::rsp_type out_data
);
   import flb_pkg::*;

   localparam int AW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;

   logic [31:0] mem [MAX_ORBITALS];
   state_type state_ff, state_in;
   logic [6:0] n_ff, n_in, i_ff, i_in, cnt_ff, cnt_in, rc_ff, rc_in, r_ff, r_in, rj_ff;
   logic [5:0] k_ff, k_in;
   logic [31:0] ei_ff, ei_in, lo_ff, lo_in, hi_ff, hi_in, probe_ff, probe_in, rd_ff;
   logic [22:0] acc_ff, acc_in;
   logic init_ff, init_in, bpos_ff, bpos_in, bneg_ff, bneg_in, conv_ff, conv_in;
   logic [8:0] iter_ff, iter_in;
   logic [16:0] hold_ff, hold_in;
   logic rv_ff, en_ff, issue, occ_en, wr_en;
   logic [6:0] addr;
   logic occ_valid;
   logic [16:0] occ_val;
   logic [6:0] oc, nc;
   logic [6:0] kc;
   logic signed [23:0] a_diff;
   logic [23:0] a_abs;
   logic [32:0] width;
   logic same, stop;
   logic [31:0] nlo, nhi;

   flb_occ #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_occ (
      .clock(clock), .reset(reset), .in_valid(rv_ff && en_ff), .energy(rd_ff),
      .probe(probe_ff), .beta(cfg.inverse_temperature),
      .out_valid(occ_valid), .occupation(occ_val)
   );

   always_comb begin
      oc = cfg.orbital_count;
      if (oc < 7'd2) nc = 7'd2;
      else if (oc > 7'(MAX_ORBITALS)) nc = 7'(MAX_ORBITALS);
      else nc = oc;
      if (cfg.electron_count < 6'd1) kc = 7'd1;
      else if ({1'b0, cfg.electron_count} > nc - 7'd1) kc = nc - 7'd1;
      else kc = {1'b0, cfg.electron_count};
   end

   always_comb begin
      a_diff = $signed({1'b0, acc_ff}) - $signed({1'b0, k_ff, 16'd0});
      a_abs = a_diff[23] ? 24'(-a_diff) : a_diff;
      width = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff};
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; k_in = k_ff; i_in = i_ff; cnt_in = cnt_ff; rc_in = rc_ff; r_in = r_ff;
      ei_in = ei_ff; lo_in = lo_ff; hi_in = hi_ff; probe_in = probe_ff; acc_in = acc_ff;
      init_in = init_ff; bpos_in = bpos_ff; bneg_in = bneg_ff; conv_in = conv_ff;
      iter_in = iter_ff; hold_in = hold_ff;
      in_pop = 1'b0; out_push = 1'b0; issue = 1'b0; occ_en = 1'b0; wr_en = 1'b0;
      addr = cnt_ff;
      same = 1'b0; stop = 1'b0; nlo = lo_ff; nhi = hi_ff;
      out_data.result_index = i_ff[5:0];
      out_data.occupation = hold_ff;
      out_data.fermi_level = probe_ff;
      out_data.converged = conv_ff;
      out_data.last = (i_ff == n_ff - 7'd1);
      case (state_ff)
         ST_IDLE: begin
            if (!in_empty) begin
               in_pop = 1'b1;
               if (in_data.action == ACT_LOAD) begin
                  wr_en = ({1'b0, in_data.orbital_index} < 7'(MAX_ORBITALS));
               end else begin
                  n_in = nc;
                  k_in = kc[5:0];
                  i_in = 7'd0;
                  iter_in = 9'd0;
                  state_in = ST_RANK_RD;
               end
            end
         end
         ST_RANK_RD: begin
            issue = 1'b1;
            addr = i_ff;
            state_in = ST_RANK_LATCH;
         end
         ST_RANK_LATCH: begin
            ei_in = rd_ff;
            r_in = 7'd0;
            cnt_in = 7'd0;
            state_in = ST_RANK_SWEEP;
         end
         ST_RANK_SWEEP: begin
            if (cnt_ff < n_ff) begin
               issue = 1'b1;
               cnt_in = cnt_ff + 7'd1;
            end
            if (rv_ff && (($signed(rd_ff) < $signed(ei_ff)) ||
                          (rd_ff == ei_ff && rj_ff < i_ff))) begin
               r_in = r_ff + 7'd1;
            end
            if (cnt_ff == n_ff && !rv_ff) begin
               if (r_ff == {1'b0, k_ff} - 7'd1) lo_in = ei_ff;
               if (r_ff == {1'b0, k_ff}) hi_in = ei_ff;
               i_in = i_ff + 7'd1;
               if (i_ff + 7'd1 == n_ff) begin
                  probe_in = (r_ff == {1'b0, k_ff} - 7'd1) ? ei_ff : lo_ff;
                  init_in = 1'b1;
                  cnt_in = 7'd0;
                  rc_in = 7'd0;
                  acc_in = 23'd0;
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_RANK_RD;
               end
            end
         end
         ST_SUM: begin
            if (cnt_ff < n_ff) begin
               issue = 1'b1;
               occ_en = 1'b1;
               cnt_in = cnt_ff + 7'd1;
            end
            if (occ_valid) begin
               acc_in = acc_ff + 23'(occ_val);
               rc_in = rc_ff + 7'd1;
               if (rc_ff + 7'd1 == n_ff) state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cnt_in = 7'd0;
            rc_in = 7'd0;
            acc_in = 23'd0;
            if (init_ff) begin
               bpos_in = (a_diff > 0);
               bneg_in = (a_diff < 0);
               init_in = 1'b0;
               probe_in = midpoint(lo_ff, hi_ff);
               state_in = ST_SUM;
            end else begin
               conv_in = (a_abs <= 24'(SUM_TOL));
               stop = (a_abs <= 24'(SUM_TOL)) || ($signed(width) <= 33'sd33);
               if (stop) begin
                  i_in = 7'd0;
                  state_in = ST_OUT_ISSUE;
               end else begin
                  iter_in = iter_ff + 9'd1;
                  same = ((a_diff > 0) && bpos_ff) || ((a_diff < 0) && bneg_ff);
                  if (same) begin
                     nlo = probe_ff;
                     bpos_in = (a_diff > 0);
                     bneg_in = (a_diff < 0);
                  end else begin
                     nhi = probe_ff;
                  end
                  lo_in = nlo;
                  hi_in = nhi;
                  if (iter_ff + 9'd1 >= cfg.iteration_limit) begin
                     i_in = 7'd0;
                     state_in = ST_OUT_ISSUE;
                  end else begin
                     probe_in = midpoint(nlo, nhi);
                     state_in = ST_SUM;
                  end
               end
            end
         end
         ST_OUT_ISSUE: begin
            issue = 1'b1;
            occ_en = 1'b1;
            addr = i_ff;
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (occ_valid) begin
               hold_in = occ_val;
               state_in = ST_OUT_PUSH;
            end
         end
         ST_OUT_PUSH: begin
            if (!out_full) begin
               out_push = 1'b1;
               i_in = i_ff + 7'd1;
               state_in = (i_ff == n_ff - 7'd1) ? ST_IDLE : ST_OUT_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         en_ff <= 1'b0;
         lo_ff <= 32'd0;
         hi_ff <= 32'd0;
         iter_ff <= 9'd0;
      end else begin
         state_ff <= state_in;
         rv_ff <= issue;
         en_ff <= occ_en;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; k_ff <= k_in; i_ff <= i_in; cnt_ff <= cnt_in; rc_ff <= rc_in;
      r_ff <= r_in; ei_ff <= ei_in; probe_ff <= probe_in; acc_ff <= acc_in;
      init_ff <= init_in; bpos_ff <= bpos_in; bneg_ff <= bneg_in; conv_ff <= conv_in;
      hold_ff <= hold_in;
      rj_ff <= addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[in_data.orbital_index[AW-1:0]] <= in_data.energy;
      rd_ff <= mem[addr[AW-1:0]];
   end
endmodule

### src/fermi_level_bisection.sv
// Fermi level search by bisection over a bank of orbital energies.
// Requests enter through a two-entry queue (req_push / req_full). A load
// request writes one Q8.24 energy into the store. A solve request ranks the
// first n energies to find the bracket, then bisects: each pass streams all
// n orbitals through the store read and a three-stage occupation pipeline,
// with one extra pass at the start for the lower bracket end. Finally each
// orbital yields one result, oldest first on the rsp_ ports while rsp_empty
// is low; rsp_pop takes it. Results wait in a two-entry queue; when it is
// full the back end holds and the input queue fills, so nothing is lost.
// Each result is pushed before the read for the next orbital is issued.
// Synchronous reset empties both queues, returns to idle and loads the
// register defaults; the energy store is not cleared and must be loaded
// before a solve. Registers are written by csr_write and should change only
// when the block is idle.
module fermi_level_bisection #(
   parameter int MAX_ORBITALS = flb_pkg::MAX_ORBITALS_DEF,
   parameter int EXP_TABLE_DEPTH = flb_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [5:0]  req_orbital_index,
   input  logic signed [31:0] req_energy,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [5:0]  rsp_result_index,
   output logic [16:0] rsp_occupation,
   output logic signed [31:0] rsp_fermi_level,
   output logic        rsp_converged,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import flb_pkg::*;

   cfg_type cfg_ff;
   req_type req_in, req_q;
   rsp_type rsp_in, rsp_q;
   logic q_empty, q_pop, o_full, o_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.electron_count <= 6'd1;
         cfg_ff.orbital_count <= 7'd64;
         cfg_ff.inverse_temperature <= 32'd65536;
         cfg_ff.iteration_limit <= 9'd500;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_ELECTRON_COUNT: cfg_ff.electron_count <= csr_data[5:0];
            CSR_ORBITAL_COUNT:  cfg_ff.orbital_count <= csr_data[6:0];
            CSR_INV_TEMP:       cfg_ff.inverse_temperature <= csr_data;
            CSR_ITER_LIMIT:     cfg_ff.iteration_limit <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign req_in.action = req_action;
   assign req_in.orbital_index = req_orbital_index;
   assign req_in.energy = req_energy;

   flb_fifo #(.WIDTH($bits(req_type))) u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full), .data_in(req_in),
      .pop(q_pop), .empty(q_empty), .data_out(req_q)
   );

   flb_back #(.MAX_ORBITALS(MAX_ORBITALS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .in_empty(q_empty), .in_data(req_q),
      .in_pop(q_pop), .out_full(o_full), .out_push(o_push), .out_data(rsp_in)
   );

   flb_fifo #(.WIDTH($bits(rsp_type))) u_result (
      .clock(clock), .reset(reset), .push(o_push), .full(o_full), .data_in(rsp_in),
      .pop(rsp_pop), .empty(rsp_empty), .data_out(rsp_q)
   );

   assign rsp_result_index = rsp_q.result_index;
   assign rsp_occupation = rsp_q.occupation;
   assign rsp_fermi_level = rsp_q.fermi_level;
   assign rsp_converged = rsp_q.converged;
   assign rsp_last = rsp_q.last;
endmodule
